[sv/bitmap_page_allocator_macros.svh]
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// shared property wrappers, clocked on i_clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, codes and types of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int          MAX_PAGES_DEF = 4096;
    localparam int          WORD_BITS     = 64;
    localparam int          STEP_BITS     = 8;
    localparam int          PAGE_SHIFT    = 12;
    localparam int          COUNT_W       = 13;
    localparam int          ADDR_W        = 32;
    localparam int          STATUS_W      = 2;
    localparam int          REG_INDEX_W   = 2;
    localparam logic [31:0] BASE_RESET    = 32'hc010_0000;
    localparam logic [12:0] POOL_RESET    = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLAIM = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    localparam logic [REG_INDEX_W-1:0] REG_BASE = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_POOL = 2'd1;

    typedef struct packed {
        logic               found;
        logic               last;
        logic [2:0]         pos;
        logic [COUNT_W-1:0] run;
    } t_scan_res;

endpackage

[sv/bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit page allocator over a used-page bitmap held in 64-bit ram words
// ----------------------------------------------------------------------------
// a claim in the pool reads and marks its word (S_MREAD, S_MWRITE), else S_DONE;
//   an allocation past the count check fetches (S_FETCH) and scans (S_SCAN) each
//   word, then reads and marks each word of the run (S_MREAD, S_MWRITE); a failed
//   count check goes straight to S_DONE
// one request at a time; 8 pages scanned per cycle in S_SCAN, one ram read per word
// reset: synchronous; clears every bitmap word with s_axis_tready low until it ends
module bitmap_page_allocator import bpa_pkg::*; #(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [REG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation [0], page_count [13:1], address [45:14], zero [47:46]
    input  logic [47:0]            s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // status [1:0], page_address [33:2], zero [39:34]
    output logic [39:0]            m_axis_tdata
);

`include "bitmap_page_allocator_macros.svh"

    localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int LW        = $clog2(MAX_PAGES + 1);
    localparam int WSH       = $clog2(WORD_BITS);
    localparam int BSH       = $clog2(STEP_BITS);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_FETCH  = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_FOUND  = 8'b0001_0000,
        S_MREAD  = 8'b0010_0000,
        S_MWRITE = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state                r_state;
    logic [31:0]           r_base;
    logic [COUNT_W-1:0]    r_pool;
    logic [AW-1:0]         r_clr;
    logic                  r_op;
    logic [COUNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]     r_addr;
    logic [LW-1:0]         r_page;
    logic [COUNT_W-1:0]    r_run;
    logic [LW-1:0]         r_start;
    logic [LW-1:0]         r_end;
    logic [AW-1:0]         r_mw;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [ADDR_W-1:0]     r_out_addr;

    logic                  in_op;
    logic [COUNT_W-1:0]    in_count;
    logic [ADDR_W-1:0]     in_addr;
    logic [LW-1:0]         limit;
    logic [ADDR_W-1:0]     diff;
    logic [LW-1:0]         claim_idx;
    logic                  claim_ok;
    logic                  count_ok;
    logic                  in_take;
    logic                  out_free;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_q;

    t_scan_res             scan;
    logic [STEP_BITS-1:0]  scan_bits;
    logic [2:0]            sub_idx;
    logic [LW-1:0]         n_start;
    logic [AW-1:0]         start_w;
    logic [AW-1:0]         end_w;
    logic [5:0]            lo_bit;
    logic [5:0]            hi_bit;
    logic [WORD_BITS-1:0]  mark_mask;
    logic [ADDR_W-1:0]     result_addr;

    assign in_op    = s_axis_tdata[0];
    assign in_count = s_axis_tdata[13:1];
    assign in_addr  = s_axis_tdata[45:14];

    assign limit     = (32'(r_pool) > 32'(MAX_PAGES)) ? LW'(MAX_PAGES) : LW'(r_pool);
    assign diff      = in_addr - r_base;
    assign claim_idx = LW'(diff >> PAGE_SHIFT);
    assign claim_ok  = (in_addr >= r_base) && (32'(diff >> PAGE_SHIFT) < 32'(limit));
    assign count_ok  = (in_count != '0) && (32'(in_count) <= 32'(limit));

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_pool <= POOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BASE: r_base <= i_cfg_data;
                REG_POOL: r_pool <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // scan step over the selected byte of the current word
    assign sub_idx   = 3'(r_page >> BSH);
    assign scan_bits = ram_q[{sub_idx, 3'b000} +: STEP_BITS];

    bpa_scan #(.LW(LW)) u_scan (
        .i_bits  (scan_bits),
        .i_page  (r_page),
        .i_limit (limit),
        .i_run   (r_run),
        .i_count (r_count),
        .o_res   (scan)
    );

    // mark mask for the word under write
    assign n_start   = LW'(32'(r_end) + 32'd1 - 32'(r_count));
    assign start_w   = AW'(r_start >> WSH);
    assign end_w     = AW'(r_end >> WSH);
    assign lo_bit    = (r_mw == start_w) ? 6'(r_start) : 6'd0;
    assign hi_bit    = (r_mw == end_w) ? 6'(r_end) : 6'd63;
    assign mark_mask = ({WORD_BITS{1'b1}} << lo_bit) & ({WORD_BITS{1'b1}} >> (6'd63 - hi_bit));

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_mw;
        ram_wdata = ram_q | mark_mask;
        ram_re    = 1'b0;
        ram_raddr = r_mw;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_FETCH: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_page >> WSH);
            end
            S_MREAD: begin
                ram_re = 1'b1;
            end
            S_MWRITE: begin
                ram_we = 1'b1;
            end
            default: ;
        endcase
    end

    bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS), .AW(AW)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(MAP_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_take) begin
                        r_op    <= in_op;
                        r_count <= in_count;
                        r_addr  <= in_addr;
                        r_page  <= '0;
                        r_run   <= '0;
                        r_start <= claim_idx;
                        r_end   <= claim_idx;
                        r_mw    <= AW'(claim_idx >> WSH);
                        if (in_op == OP_CLAIM) begin
                            r_status <= claim_ok ? ST_OK : ST_RANGE;
                            r_state  <= claim_ok ? S_MREAD : S_DONE;
                        end else begin
                            r_status <= count_ok ? ST_OK : ST_NOFIT;
                            r_state  <= count_ok ? S_FETCH : S_DONE;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan.found) begin
                        r_end   <= LW'(32'(r_page) + 32'(scan.pos));
                        r_state <= S_FOUND;
                    end else if (scan.last) begin
                        r_status <= ST_NOFIT;
                        r_state  <= S_DONE;
                    end else begin
                        r_page <= LW'(32'(r_page) + 32'(STEP_BITS));
                        r_run  <= scan.run;
                        if (sub_idx == 3'd7) begin
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FOUND: begin
                    r_start <= n_start;
                    r_mw    <= AW'(n_start >> WSH);
                    r_state <= S_MREAD;
                end
                S_MREAD: begin
                    r_state <= S_MWRITE;
                end
                S_MWRITE: begin
                    if (r_mw == end_w) begin
                        r_state <= S_DONE;
                    end else begin
                        r_mw    <= r_mw + 1'b1;
                        r_state <= S_MREAD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // result value
    always_comb begin
        if (r_status != ST_OK) begin
            result_addr = '0;
        end else if (r_op == OP_CLAIM) begin
            result_addr = r_addr;
        end else begin
            result_addr = r_base + (32'(r_start) << PAGE_SHIFT);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_status <= r_status;
            r_out_addr   <= result_addr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_addr, r_out_status};

    `BPA_ASSERT_NEXT(a_one_request, in_take, !s_axis_tready,
        "second request taken while busy")
    `BPA_ASSERT_NOW(a_mark_range, r_state == S_MWRITE,
        (mark_mask != '0) && (r_mw >= start_w) && (r_mw <= end_w),
        "mark write outside the run")
    `BPA_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (r_out_status != ST_OK),
        r_out_addr == '0, "failed request carries an address")

endmodule

[sv/bpa_ram.sv]
// ----------------------------------------------------------------------------
// bpa_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bpa_scan.sv]
// ----------------------------------------------------------------------------
// bpa_scan
// first-fit step over eight pages, carries the free-run length across steps
// ----------------------------------------------------------------------------
module bpa_scan import bpa_pkg::*; #(
    parameter int LW = 13
) (
    input  logic [STEP_BITS-1:0] i_bits,
    input  logic [LW-1:0]        i_page,
    input  logic [LW-1:0]        i_limit,
    input  logic [COUNT_W-1:0]   i_run,
    input  logic [COUNT_W-1:0]   i_count,
    output t_scan_res            o_res
);

    always_comb begin
        logic [COUNT_W-1:0] run;
        logic               found;
        logic [2:0]         pos;
        run   = i_run;
        found = 1'b0;
        pos   = 3'd0;
        for (int j = 0; j < STEP_BITS; j++) begin
            if (!found && (32'(i_page) + 32'(j) < 32'(i_limit))) begin
                if (i_bits[j]) begin
                    run = '0;
                end else begin
                    run = run + 1'b1;
                    if (run == i_count) begin
                        found = 1'b1;
                        pos   = 3'(j);
                    end
                end
            end
        end
        o_res.found = found;
        o_res.pos   = pos;
        o_res.run   = run;
        o_res.last  = (32'(i_page) + 32'(STEP_BITS)) >= 32'(i_limit);
    end

endmodule
